@@ hw/rtl/qpc_pkg.sv @@
// Shared types and constants for the queue-pressure signal phase controller.
// No dependencies; used by qpc_step, the top level and the checker.
package qpc_pkg;

   // Fixed geometry
   localparam int NUM_DIRS    = 4;
   localparam int MAX_PHASES  = 4;
   localparam int PHASE_W     = 2;
   localparam int DIR_W       = 2;
   localparam int OUT_COUNT_W = 16;

   // Defaults for top-level parameters
   localparam int COUNT_WIDTH = 16;
   localparam int TIME_WIDTH  = 8;

   // Register reset values
   localparam logic [2:0]  PHASE_COUNT_RST = 3'd2;
   localparam logic [15:0] PHASE_MASKS_RST = 16'h00A5;
   localparam logic [31:0] MIN_GREEN_RST   = 32'h0505_0505;
   localparam logic [31:0] MAX_GREEN_RST   = 32'h0F0F_0F0F;

   // Item opcodes
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // CSR word index (paddr[3:2])
   typedef enum logic [1:0] {
      REG_PHASE_COUNT = 2'd0,
      REG_PHASE_MASKS = 2'd1,
      REG_MIN_GREEN   = 2'd2,
      REG_MAX_GREEN   = 2'd3
   } reg_index_type;

   // Per-item outcome besides the queue counts
   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic                switched;
      logic [NUM_DIRS-1:0] passed;
   } step_result_type;

endpackage

@@ hw/rtl/qpc_step.sv @@
// Next-state logic for one item: queue update, pressure sums, phase choice.
// Depends on qpc_pkg.
module qpc_step #(
   parameter int COUNT_WIDTH = qpc_pkg::COUNT_WIDTH,
   parameter int TIME_WIDTH  = qpc_pkg::TIME_WIDTH
) (
   input  logic                        opcode,
   input  logic [qpc_pkg::DIR_W-1:0]   arrival_direction,
   input  logic [COUNT_WIDTH-1:0]      counts_cur [qpc_pkg::NUM_DIRS],
   input  logic [qpc_pkg::PHASE_W-1:0] phase_cur,
   input  logic [TIME_WIDTH-1:0]       elapsed_cur,
   input  logic [2:0]                  phase_count,
   input  logic [15:0]                 phase_masks,
   input  logic [31:0]                 min_green_each,
   input  logic [31:0]                 max_green_each,
   output logic [COUNT_WIDTH-1:0]      counts_next [qpc_pkg::NUM_DIRS],
   output logic [TIME_WIDTH-1:0]       elapsed_next,
   output qpc_pkg::step_result_type    result
);

   localparam int PW = COUNT_WIDTH + 2;                   // sum of four counts
   localparam int EW = (TIME_WIDTH > 8) ? TIME_WIDTH : 8;  // elapsed vs byte limits
   localparam int PHASE_W_L = qpc_pkg::PHASE_W;

   logic [3:0]             green_mask;
   logic [7:0]             min_byte;
   logic [7:0]             max_byte;
   logic [2:0]             n_eff;
   logic [2:0]             next_turn;
   logic [TIME_WIDTH-1:0]  elapsed_inc;
   logic [COUNT_WIDTH-1:0] dec_counts [qpc_pkg::NUM_DIRS];
   logic [3:0]             pass_bits;
   logic [PW-1:0]          press [qpc_pkg::MAX_PHASES];
   logic [PHASE_W_L-1:0]   best;
   logic [PW-1:0]          best_score;
   logic [EW-1:0]          el_ext;

   assign green_mask = phase_masks[{phase_cur, 2'b00} +: 4];
   assign min_byte   = min_green_each[{phase_cur, 3'b000} +: 8];
   assign max_byte   = max_green_each[{phase_cur, 3'b000} +: 8];

   // 0 acts as one phase, anything above the phase limit is clamped
   assign n_eff = (phase_count == 3'd0) ? 3'd1 :
                  (phase_count > 3'(qpc_pkg::MAX_PHASES)) ? 3'(qpc_pkg::MAX_PHASES) :
                  phase_count;

   assign next_turn = (({1'b0, phase_cur} + 3'd1) >= n_eff) ? 3'd0
                                                           : ({1'b0, phase_cur} + 3'd1);

   assign elapsed_inc = (elapsed_cur == '1) ? elapsed_cur : elapsed_cur + 1'b1;
   assign el_ext      = EW'(elapsed_inc);

   // one vehicle leaves each green, non-empty approach
   always_comb begin
      for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
         pass_bits[d]  = green_mask[d] && (counts_cur[d] != '0);
         dec_counts[d] = pass_bits[d] ? counts_cur[d] - 1'b1 : counts_cur[d];
      end
   end

   // pressure per phase, on the drained counts
   always_comb begin
      for (int p = 0; p < qpc_pkg::MAX_PHASES; p++) begin
         press[p] = '0;
         for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
            if (phase_masks[4*p + d]) begin
               press[p] = press[p] + PW'(dec_counts[d]);
            end
         end
      end
   end

   // strictly larger wins; the current phase keeps ties, else lowest index; max green forces next in turn
   always_comb begin
      best       = phase_cur;
      best_score = press[phase_cur];
      for (int p = 0; p < qpc_pkg::MAX_PHASES; p++) begin
         if ((3'(p) < n_eff) && (PHASE_W_L'(p) != phase_cur) && (press[p] > best_score)) begin
            best       = PHASE_W_L'(p);
            best_score = press[p];
         end
      end
      if (el_ext >= EW'(max_byte)) begin
         best = next_turn[PHASE_W_L-1:0];
      end
   end

   always_comb begin
      result.phase    = phase_cur;
      result.switched = 1'b0;
      result.passed   = '0;
      elapsed_next    = elapsed_cur;
      for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
         counts_next[d] = counts_cur[d];
      end

      if (opcode == qpc_pkg::OP_ARRIVAL) begin
         for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
            if ((qpc_pkg::DIR_W'(d) == arrival_direction) && (counts_cur[d] != '1)) begin
               counts_next[d] = counts_cur[d] + 1'b1;
            end
         end
      end else begin
         counts_next   = dec_counts;
         result.passed = pass_bits;
         elapsed_next  = elapsed_inc;
         if ((el_ext >= EW'(min_byte)) && (best != phase_cur)) begin
            result.phase    = best;
            result.switched = 1'b1;
            elapsed_next    = '0;
         end
      end
   end

endmodule

@@ hw/rtl/queue_pressure_signal_phase_controller.sv @@
// Top level of the queue-pressure signal phase controller: CSRs, input and
// result registers, controller state. Depends on qpc_pkg and qpc_step.
//
//   channel | prefix | handshake            | payload
//   --------+--------+----------------------+------------------------------------
//   input   | req_   | req_valid/req_stall  | opcode, arrival_direction
//   result  | rsp_   | rsp_valid/rsp_stall  | phase, switched, passed, 4 queues
//   config  | APB    | psel/penable/pready  | paddr[3:2] word index, 32-bit data
//
// Throughput is one beat per cycle while the result is not stalled. The input
// register loads at the accepting edge, the result register and rsp_valid when
// the beat retires from it. Per-item work is qpc_step: four drained queue counts,
// four pressure adders and a four-way ordered compare, all combinational.
// Reset is synchronous and clears queues, phase, elapsed time, CSRs to defaults
// and both valid flags. A stalled result holds; the input register still takes
// a new beat while the result waits, and req_stall rises only when both are full.
module queue_pressure_signal_phase_controller #(
   parameter int COUNT_WIDTH = qpc_pkg::COUNT_WIDTH,
   parameter int TIME_WIDTH  = qpc_pkg::TIME_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [qpc_pkg::DIR_W-1:0]       req_arrival_direction,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [qpc_pkg::PHASE_W-1:0]     rsp_phase_now,
   output logic                            rsp_phase_switched,
   output logic [qpc_pkg::NUM_DIRS-1:0]    rsp_passed_mask,
   output logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_north_waiting,
   output logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_east_waiting,
   output logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_south_waiting,
   output logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_west_waiting,
   // configuration
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [3:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   localparam int OW = (COUNT_WIDTH > qpc_pkg::OUT_COUNT_W) ? COUNT_WIDTH
                                                           : qpc_pkg::OUT_COUNT_W;

   // ---------------- CSRs ----------------
   logic [2:0]  phase_count_ff;
   logic [15:0] phase_masks_ff;
   logic [31:0] min_green_ff;
   logic [31:0] max_green_ff;
   logic        csr_write;
   qpc_pkg::reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = qpc_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_count_ff <= qpc_pkg::PHASE_COUNT_RST;
         phase_masks_ff <= qpc_pkg::PHASE_MASKS_RST;
         min_green_ff   <= qpc_pkg::MIN_GREEN_RST;
         max_green_ff   <= qpc_pkg::MAX_GREEN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            qpc_pkg::REG_PHASE_COUNT: phase_count_ff <= pwdata[2:0];
            qpc_pkg::REG_PHASE_MASKS: phase_masks_ff <= pwdata[15:0];
            qpc_pkg::REG_MIN_GREEN:   min_green_ff   <= pwdata;
            qpc_pkg::REG_MAX_GREEN:   max_green_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         qpc_pkg::REG_PHASE_COUNT: prdata = {29'd0, phase_count_ff};
         qpc_pkg::REG_PHASE_MASKS: prdata = {16'd0, phase_masks_ff};
         qpc_pkg::REG_MIN_GREEN:   prdata = min_green_ff;
         qpc_pkg::REG_MAX_GREEN:   prdata = max_green_ff;
         default:                  prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   logic                      in_valid_ff, in_valid_in;
   logic                      in_opcode_ff;
   logic [qpc_pkg::DIR_W-1:0] in_dir_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;    // result register can load
   logic                      stage_adv;   // input beat retires this cycle
   logic                      req_accept;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign stage_adv    = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !out_free);
   assign rsp_valid_in = stage_adv || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_opcode_ff <= req_opcode;
         in_dir_ff    <= req_arrival_direction;
      end
   end

   // ---------------- controller state ----------------
   logic [COUNT_WIDTH-1:0]      counts_ff  [qpc_pkg::NUM_DIRS];
   logic [COUNT_WIDTH-1:0]      counts_in  [qpc_pkg::NUM_DIRS];
   logic [qpc_pkg::PHASE_W-1:0] phase_ff;
   logic [TIME_WIDTH-1:0]       elapsed_ff, elapsed_in;
   qpc_pkg::step_result_type    step_res;
   logic [OW-1:0]               cnt_ext [qpc_pkg::NUM_DIRS];

   qpc_step #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_step (
      .opcode            (in_opcode_ff),
      .arrival_direction (in_dir_ff),
      .counts_cur        (counts_ff),
      .phase_cur         (phase_ff),
      .elapsed_cur       (elapsed_ff),
      .phase_count       (phase_count_ff),
      .phase_masks       (phase_masks_ff),
      .min_green_each    (min_green_ff),
      .max_green_each    (max_green_ff),
      .counts_next       (counts_in),
      .elapsed_next      (elapsed_in),
      .result            (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
            counts_ff[d] <= '0;
         end
         phase_ff   <= '0;
         elapsed_ff <= '0;
      end else if (stage_adv) begin
         counts_ff  <= counts_in;
         phase_ff   <= step_res.phase;
         elapsed_ff <= elapsed_in;
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
         cnt_ext[d] = OW'(counts_in[d]);
      end
   end

   logic [qpc_pkg::PHASE_W-1:0]     rsp_phase_ff;
   logic                            rsp_switched_ff;
   logic [qpc_pkg::NUM_DIRS-1:0]    rsp_passed_ff;
   logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_queue_ff [qpc_pkg::NUM_DIRS];

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_phase_ff    <= step_res.phase;
         rsp_switched_ff <= step_res.switched;
         rsp_passed_ff   <= step_res.passed;
         for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
            rsp_queue_ff[d] <= cnt_ext[d][qpc_pkg::OUT_COUNT_W-1:0];
         end
      end
   end

   assign rsp_phase_now      = rsp_phase_ff;
   assign rsp_phase_switched = rsp_switched_ff;
   assign rsp_passed_mask    = rsp_passed_ff;
   assign rsp_north_waiting  = rsp_queue_ff[0];
   assign rsp_east_waiting   = rsp_queue_ff[1];
   assign rsp_south_waiting  = rsp_queue_ff[2];
   assign rsp_west_waiting   = rsp_queue_ff[3];

endmodule

@@ hw/rtl/qpc_checker.sv @@
// Port-level checks for the phase controller, plus the bind that attaches them.
// Depends on qpc_pkg and the top level's port list.
module qpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [qpc_pkg::PHASE_W-1:0]     rsp_phase_now,
   input logic                            rsp_phase_switched,
   input logic [qpc_pkg::NUM_DIRS-1:0]    rsp_passed_mask,
   input logic [qpc_pkg::OUT_COUNT_W-1:0] rsp_north_waiting
);

   logic                            rsp_beat;
   logic                            seen_ff;
   logic [qpc_pkg::PHASE_W-1:0]     last_phase_ff;
   logic [qpc_pkg::OUT_COUNT_W-1:0] last_north_ff;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // last delivered result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_beat) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat) begin
         last_phase_ff <= rsp_phase_now;
         last_north_ff <= rsp_north_waiting;
      end
   end

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase_now)
                              && $stable(rsp_phase_switched) && $stable(rsp_passed_mask))
      else $error("stalled result changed");

   // phase only moves on a beat flagged as a switch
   a_phase_moves: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_ff |-> (rsp_phase_switched == (rsp_phase_now != last_phase_ff)))
      else $error("phase change and switch flag disagree");

   // a north departure drops the north queue by exactly one
   a_north_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && seen_ff && rsp_passed_mask[0]
         |-> rsp_north_waiting == last_north_ff - 1'b1)
      else $error("north departure without matching queue drop");

endmodule

bind queue_pressure_signal_phase_controller qpc_checker u_qpc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_phase_now      (rsp_phase_now),
   .rsp_phase_switched (rsp_phase_switched),
   .rsp_passed_mask    (rsp_passed_mask),
   .rsp_north_waiting  (rsp_north_waiting)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for queue_pressure_signal_phase_controller: a directed table, then
// random traffic under several register settings, checked against typed rows or a local model.
// Depends on qpc_pkg and the controller RTL; nothing else.
module tb;

   localparam int          HALF_PERIOD     = 10;
   localparam int unsigned QUEUE_CAP       = (1 << qpc_pkg::COUNT_WIDTH) - 1;
   localparam int unsigned AGE_CAP         = (1 << qpc_pkg::TIME_WIDTH) - 1;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int          BEATS_PER_PHASE = 80;
   localparam int          PRINT_CAP       = 100;
   localparam int          PLAN_ROWS       = 28;

   // short names for the codes used in the table
   localparam logic ARRIVE = qpc_pkg::OP_ARRIVAL;
   localparam logic TICK   = qpc_pkg::OP_TICK;
   localparam qpc_pkg::reg_index_type R_COUNT = qpc_pkg::REG_PHASE_COUNT;
   localparam qpc_pkg::reg_index_type R_MASKS = qpc_pkg::REG_PHASE_MASKS;
   localparam qpc_pkg::reg_index_type R_MIN   = qpc_pkg::REG_MIN_GREEN;
   localparam qpc_pkg::reg_index_type R_MAX   = qpc_pkg::REG_MAX_GREEN;

   // One result beat: phase/switch/pass flags plus the four queue lengths,
   // indexed north, east, south, west.
   typedef struct packed {
      qpc_pkg::step_result_type                               step;
      logic [0:qpc_pkg::NUM_DIRS-1][qpc_pkg::OUT_COUNT_W-1:0] waiting;
   } signal_outcome_type;

   typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_type;

   // Directed row: either an input beat (typed = expected result spelled out
   // below, else taken from the model) or a register write done while idle.
   typedef struct packed {
      row_kind_type                kind;
      qpc_pkg::reg_index_type      csr;
      logic [31:0]                 value;
      logic                        op;
      logic [qpc_pkg::DIR_W-1:0]   dir;
      logic                        typed;
      signal_outcome_type          want;
   } plan_row_type;

   localparam signal_outcome_type NO_WANT = '0;

   // Starts from reset: two phases, phase 0 greens north+south, phase 1
   // east+west, min green 5, max green 15.
   localparam plan_row_type DIRECTED_PLAN [PLAN_ROWS] = '{
      // first tick on empty queues: nothing moves
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd0, 16'd0, 16'd0, 16'd0}}},
      // one arrival on each approach, two on west
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd0, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd1, 16'd0, 16'd0, 16'd0}}},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd1, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd1, 16'd1, 16'd0, 16'd0}}},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd2, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd1, 16'd1, 16'd1, 16'd0}}},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd3, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd1, 16'd1, 16'd1, 16'd1}}},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd3, 1'b1,
        '{'{2'd0, 1'b0, 4'h0}, '{16'd1, 16'd1, 16'd1, 16'd2}}},
      // tick with a direction that must be ignored: north and south drain
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd3, 1'b1,
        '{'{2'd0, 1'b0, 4'h5}, '{16'd0, 16'd1, 16'd0, 16'd2}}},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT},
      // min green reached, east+west carry more load: switch to phase 1
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b1,
        '{'{2'd1, 1'b1, 4'h0}, '{16'd0, 16'd1, 16'd0, 16'd2}}},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd1, 1'b1,
        '{'{2'd1, 1'b0, 4'hA}, '{16'd0, 16'd0, 16'd0, 16'd1}}},
      // zero green limits, four phases: every tick turns to the next phase
      '{ROW_WRITE, R_MIN, 32'h0, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_WRITE, R_MAX, 32'h0, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_WRITE, R_COUNT, 32'd4, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd2, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd1, 1'b0, NO_WANT},
      // now in phase 3; shrink the count so the current phase is out of range
      '{ROW_WRITE, R_COUNT, 32'd2, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT},
      // identical masks everywhere: ties never switch
      '{ROW_WRITE, R_MAX, 32'h0F0F_0F0F, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_WRITE, R_MASKS, 32'h0000_FFFF, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd3, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, ARRIVE, 2'd2, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd3, 1'b0, NO_WANT},
      // a phase count of zero behaves as one phase
      '{ROW_WRITE, R_COUNT, 32'd0, ARRIVE, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT},
      '{ROW_BEAT, R_COUNT, 32'h0, TICK, 2'd0, 1'b0, NO_WANT}
   };

   // DUT ports; every input holds a known value from time zero
   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_opcode = ARRIVE;
   logic [qpc_pkg::DIR_W-1:0]          req_arrival_direction = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [qpc_pkg::PHASE_W-1:0]        rsp_phase_now;
   logic                               rsp_phase_switched;
   logic [qpc_pkg::NUM_DIRS-1:0]       rsp_passed_mask;
   logic [qpc_pkg::OUT_COUNT_W-1:0]    rsp_north_waiting;
   logic [qpc_pkg::OUT_COUNT_W-1:0]    rsp_east_waiting;
   logic [qpc_pkg::OUT_COUNT_W-1:0]    rsp_south_waiting;
   logic [qpc_pkg::OUT_COUNT_W-1:0]    rsp_west_waiting;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [3:0]                         paddr = '0;
   logic [31:0]                        pwdata = '0;
   logic [31:0]                        prdata;
   logic                               pready;

   // Typed expectation riding along with the beat on the input bus; driven
   // with nonblocking updates so the monitor sees the value of the beat taken.
   logic                               beat_typed = 1'b0;
   signal_outcome_type                 beat_want = '0;

   // Controller model: register copies and state
   logic [2:0]                         set_phase_count;
   logic [15:0]                        set_masks;
   logic [31:0]                        set_min_green;
   logic [31:0]                        set_max_green;
   int unsigned                        lane_queue [qpc_pkg::NUM_DIRS];
   int unsigned                        phase_idx;
   int unsigned                        green_age;

   signal_outcome_type                 due_outcomes [$];
   int                                 fault_count = 0;
   int                                 results_checked = 0;
   int unsigned                        cycle_count = 0;
   int                                 gap_pct = 21;    // sender idle, percent of cycles
   int                                 stall_pct = 63;  // receiver stall, percent of cycles
   string                              approach_names [qpc_pkg::NUM_DIRS] =
      '{"north_waiting", "east_waiting", "south_waiting", "west_waiting"};

   queue_pressure_signal_phase_controller dut (.*);

   always #(HALF_PERIOD) clock = ~clock;

   // Hard stop in case a beat never gets through or a result never shows.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic log_fault(string field, longint unsigned got, longint unsigned want);
      if (fault_count < PRINT_CAP)
         $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
                  $time, field, results_checked, got, want);
      fault_count++;
   endtask

   // Summed queue length over the approaches green in a mask.
   function automatic int unsigned approach_load(logic [qpc_pkg::NUM_DIRS-1:0] green);
      int unsigned sum = 0;
      for (int d = 0; d < qpc_pkg::NUM_DIRS; d++)
         if (green[d]) sum += lane_queue[d];
      return sum;
   endfunction

   // Applies one input beat to the model and returns the result it yields.
   function automatic signal_outcome_type advance_signal(logic op,
                                                         logic [qpc_pkg::DIR_W-1:0] dir);
      signal_outcome_type           o;
      logic [qpc_pkg::NUM_DIRS-1:0] green;
      int unsigned                  in_use;
      int unsigned                  best;
      int unsigned                  best_load;
      int unsigned                  load;
      o = '0;
      if (op == ARRIVE) begin
         if (lane_queue[dir] < QUEUE_CAP) lane_queue[dir]++;
      end else begin
         in_use = (set_phase_count == 3'd0) ? 1 :
                  (int'(set_phase_count) > qpc_pkg::MAX_PHASES) ? qpc_pkg::MAX_PHASES
                                                                : int'(set_phase_count);
         green = set_masks[4*phase_idx +: 4];
         if (green_age < AGE_CAP) green_age++;
         // one car leaves each non-empty green approach
         for (int d = 0; d < qpc_pkg::NUM_DIRS; d++) begin
            if (green[d] && lane_queue[d] > 0) begin
               lane_queue[d]--;
               o.step.passed[d] = 1'b1;
            end
         end
         if (green_age >= 32'(set_min_green[8*phase_idx +: 8])) begin
            // strictly heavier phase wins; the current phase keeps ties, else lowest index first
            best = phase_idx;
            best_load = approach_load(green);
            for (int unsigned p = 0; p < in_use; p++) begin
               load = approach_load(set_masks[4*p +: 4]);
               if (p != phase_idx && load > best_load) begin
                  best = p;
                  best_load = load;
               end
            end
            // max green overrides the pressure pick with the next phase in turn
            if (green_age >= 32'(set_max_green[8*phase_idx +: 8]))
               best = (phase_idx + 1 >= in_use) ? 0 : phase_idx + 1;
            if (best != phase_idx) begin
               phase_idx = best;
               green_age = 0;
               o.step.switched = 1'b1;
            end
         end
      end
      o.step.phase = phase_idx[qpc_pkg::PHASE_W-1:0];
      for (int d = 0; d < qpc_pkg::NUM_DIRS; d++)
         o.waiting[d] = lane_queue[d][qpc_pkg::OUT_COUNT_W-1:0];
      return o;
   endfunction

   // Input-side prediction and result checking share one process so that a
   // beat taken and a result taken on the same edge are handled in fixed order.
   always @(posedge clock) begin : result_monitor
      signal_outcome_type got;
      signal_outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            want = advance_signal(req_opcode, req_arrival_direction);
            due_outcomes.insert(due_outcomes.size(), beat_typed ? beat_want : want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.step = '{rsp_phase_now, rsp_phase_switched, rsp_passed_mask};
            got.waiting = '{rsp_north_waiting, rsp_east_waiting,
                            rsp_south_waiting, rsp_west_waiting};
            if (due_outcomes.size() == 0) begin
               log_fault("unexpected result beat", 1, 0);
            end else begin
               want = due_outcomes.pop_front();
               if (got.step.phase != want.step.phase)
                  log_fault("phase_now", got.step.phase, want.step.phase);
               if (got.step.switched != want.step.switched)
                  log_fault("phase_switched", got.step.switched, want.step.switched);
               if (got.step.passed != want.step.passed)
                  log_fault("passed_mask", got.step.passed, want.step.passed);
               for (int d = 0; d < qpc_pkg::NUM_DIRS; d++)
                  if (got.waiting[d] != want.waiting[d])
                     log_fault(approach_names[d], got.waiting[d], want.waiting[d]);
            end
            results_checked++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one beat after a random gap and returns on the edge that takes it;
   // valid stays up so a following beat goes out back to back.
   task automatic drive_beat(logic op, logic [qpc_pkg::DIR_W-1:0] dir, logic typed,
                             signal_outcome_type want);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_arrival_direction <= dir;
      beat_typed <= typed;
      beat_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the input off until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_outcomes.size() != 0) @(posedge clock);
   endtask

   // APB write, then a read-back on the same select; only while idle.
   task automatic write_register(qpc_pkg::reg_index_type idx, logic [31:0] value);
      logic [31:0] kept;
      case (idx)
         qpc_pkg::REG_PHASE_COUNT: begin
            set_phase_count = value[2:0];
            kept = {29'd0, value[2:0]};
         end
         qpc_pkg::REG_PHASE_MASKS: begin
            set_masks = value[15:0];
            kept = {16'd0, value[15:0]};
         end
         qpc_pkg::REG_MIN_GREEN: begin
            set_min_green = value;
            kept = value;
         end
         default: begin
            set_max_green = value;
            kept = value;
         end
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata != kept) log_fault("register read-back", prdata, kept);
      psel <= 1'b0;
      penable <= 1'b0;
      // bus idle between transfers
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] setting [4];
      set_phase_count = qpc_pkg::PHASE_COUNT_RST;
      set_masks = qpc_pkg::PHASE_MASKS_RST;
      set_min_green = qpc_pkg::MIN_GREEN_RST;
      set_max_green = qpc_pkg::MAX_GREEN_RST;
      foreach (lane_queue[d]) lane_queue[d] = 0;
      phase_idx = 0;
      green_age = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, straight from reset defaults
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
            drain_results();
            write_register(DIRECTED_PLAN[i].csr, DIRECTED_PLAN[i].value);
         end else begin
            drive_beat(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].dir,
                       DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      // random traffic: six settings, idling pattern changes every two
      for (int p = 0; p < 6; p++) begin
         drain_results();
         gap_pct = (p < 2) ? 21 : (p < 4) ? 63 : 0;
         stall_pct = (p < 2) ? 63 : (p < 4) ? 21 : 0;
         if (p % 2 == 0) begin
            // small green limits so switches happen often; max may fall below min
            setting[0] = $urandom_range(7);
            setting[1] = $urandom;
            for (int b = 0; b < 4; b++) begin
               setting[2][8*b +: 8] = 8'($urandom_range(6));
               setting[3][8*b +: 8] = 8'($urandom_range(9));
            end
         end else if (p == 1) begin
            setting = '{32'd7, 32'h0000_FFFF, 32'h0, 32'hFFFF_FFFF};
         end else if (p == 3) begin
            // single phase with max below min: the turn comes back to itself
            setting = '{32'd1, 32'($urandom_range(16'hFFFF)), 32'h0202_0202, 32'h0};
         end else begin
            setting = '{32'd0, 32'h0, 32'hFFFF_FFFF, 32'h0};
         end
         for (int r = 0; r < 4; r++)
            write_register(qpc_pkg::reg_index_type'(r), setting[r]);
         repeat (BEATS_PER_PHASE) begin
            if ($urandom_range(49) == 0) drain_results();
            drive_beat(($urandom_range(99) < 42) ? TICK : ARRIVE,
                       qpc_pkg::DIR_W'($urandom_range(3)), 1'b0, NO_WANT);
         end
      end

      // saturation: one phase with nothing green, elapsed runs into its ceiling
      drain_results();
      setting = '{32'd1, 32'h0, 32'h0, 32'h0};
      for (int r = 0; r < 4; r++)
         write_register(qpc_pkg::reg_index_type'(r), setting[r]);
      repeat (AGE_CAP + 10)
         drive_beat(TICK, qpc_pkg::DIR_W'($urandom_range(3)), 1'b0, NO_WANT);

      // back to several phases with elapsed still pinned at its ceiling
      drain_results();
      setting = '{32'd4, 32'h8421, 32'h0301_0200, 32'h0905_0703};
      for (int r = 0; r < 4; r++)
         write_register(qpc_pkg::reg_index_type'(r), setting[r]);
      repeat (20)
         drive_beat(($urandom_range(1) == 0) ? TICK : ARRIVE,
                    qpc_pkg::DIR_W'($urandom_range(3)), 1'b0, NO_WANT);

      drain_results();
      repeat (4) @(posedge clock);
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
